// ===== hw/rtl/grlut_pkg.sv =====
// ----------------------------------------------------------------------------
// Gamma ramp LUT package
// Shared widths, register codes, reset values and the exp2 root table.
// ----------------------------------------------------------------------------
package grlut_pkg;

  localparam int IDX_W              = 16;
  localparam int REG_W              = 20;
  localparam int GAIN_W             = 19;   // magnitude bits of a positive gain
  localparam int EXP_FRAC           = 16;
  localparam int LOG_FRAC           = 30;
  localparam int LOG_INT_W          = 4;
  localparam int LOG_W              = LOG_INT_W + LOG_FRAC;
  localparam int LOG_STEPS          = 30;
  localparam int LOG_LAT            = LOG_STEPS + 1;
  localparam int EXP_STEPS          = LOG_FRAC;
  localparam int EXP_LAT            = EXP_STEPS + 2;
  localparam int Y_W                = LOG_W + REG_W - EXP_FRAC;
  localparam int EXP_N_W            = Y_W - LOG_FRAC;
  localparam int P_W                = 33;
  localparam int V_W                = P_W + GAIN_W;
  localparam int PIPE_LAT           = LOG_LAT + EXP_LAT + 4;
  localparam int DEF_INDEX_BITS     = 16;
  localparam int DEF_GAIN_FRAC_BITS = 16;

  localparam logic [IDX_W-1:0] RST_RAMP_SIZE = 16'd256;
  localparam logic [REG_W-1:0] RST_GAIN      = 20'h10000;
  localparam logic [REG_W-1:0] RST_EXP       = 20'h10000;

  typedef enum logic [2:0] {
    CFG_RAMP_SIZE   = 3'd0,
    CFG_RED_GAIN    = 3'd1,
    CFG_GREEN_GAIN  = 3'd2,
    CFG_BLUE_GAIN   = 3'd3,
    CFG_RED_EXP     = 3'd4,
    CFG_GREEN_EXP   = 3'd5,
    CFG_BLUE_EXP    = 3'd6,
    CFG_UNUSED      = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2,
    CH_NONE  = 2'd3
  } ch_t;

  // side information that travels with an item through the log stages
  typedef struct packed {
    logic              zero;
    logic              p_one;
    logic              p_zero;
    logic [GAIN_W-1:0] gain;
    logic [REG_W-1:0]  expo;
  } log_side_t;

  // side information that travels through the exp2 stages
  typedef struct packed {
    logic              zero;
    logic              p_one;
    logic              p_zero;
    logic [GAIN_W-1:0] gain;
  } exp_side_t;

  // integer square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bw;
    v   = v_in;
    res = '0;
    bw  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bw > v) bw = bw >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bw != 0) begin
        if (v >= res + bw) begin
          v   = v - (res + bw);
          res = (res >> 1) + bw;
        end else begin
          res = res >> 1;
        end
        bw = bw >> 2;
      end
    end
    return res;
  endfunction

  // roots r_k = 2^32 * 2^(-2^-k), built by repeated square roots
  function automatic logic [EXP_STEPS:1][31:0] root_table();
    logic [EXP_STEPS:1][31:0] tab;
    logic [63:0]              r;
    r = 64'd1 << 31;
    for (int k = 1; k <= EXP_STEPS; k++) begin
      r      = isqrt64(r << 32);
      tab[k] = r[31:0];
    end
    return tab;
  endfunction

endpackage

// ===== hw/rtl/grlut_log2.sv =====
// ----------------------------------------------------------------------------
// Dual-lane pipelined log2
// Computes log2 of two 16-bit operands with 30 fraction bits, one squaring
// step per stage, side information carried alongside.
// ----------------------------------------------------------------------------
module grlut_log2 import grlut_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [IDX_W-1:0]    in_a,
  input  logic [IDX_W-1:0]    in_b,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [LOG_W-1:0]    out_la,
  output logic [LOG_W-1:0]    out_lb,
  output logic [SIDE_W-1:0]   out_side
);

  logic [LOG_STEPS:0]               vld_r;
  logic [31:0]                      m_r    [2][LOG_STEPS+1];
  logic [LOG_INT_W-1:0]             k_r    [2][LOG_STEPS+1];
  logic [LOG_FRAC-1:0]              frac_r [2][LOG_STEPS+1];
  logic [SIDE_W-1:0]                side_r [LOG_STEPS+1];

  logic [31:0]                      m_nxt    [2][LOG_STEPS+1];
  logic [LOG_INT_W-1:0]             k_nxt    [2];
  logic [LOG_FRAC-1:0]              frac_nxt [2][LOG_STEPS+1];
  logic [63:0]                      sq       [2][LOG_STEPS];
  logic [IDX_W-1:0]                 opnd     [2];

  // normalise the operands and run one squaring step per stage
  always_comb begin
    opnd[0] = in_a;
    opnd[1] = in_b;
    for (int l = 0; l < 2; l++) begin
      k_nxt[l] = '0;
      for (int i = 0; i < IDX_W; i++) begin
        if (opnd[l][i]) k_nxt[l] = LOG_INT_W'(i);
      end
      m_nxt[l][0]    = 32'({16'd0, opnd[l]} << (5'd31 - {1'b0, k_nxt[l]}));
      frac_nxt[l][0] = '0;
      for (int b = 0; b < LOG_STEPS; b++) begin
        sq[l][b] = 64'(m_r[l][b]) * 64'(m_r[l][b]);
        if (sq[l][b][63]) begin
          m_nxt[l][b+1]    = sq[l][b][63:32];
          frac_nxt[l][b+1] = frac_r[l][b] | (LOG_FRAC'(1) << (LOG_FRAC - 1 - b));
        end else begin
          m_nxt[l][b+1]    = sq[l][b][62:31];
          frac_nxt[l][b+1] = frac_r[l][b];
        end
      end
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LOG_STEPS-1:0], in_valid};
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int s = 1; s <= LOG_STEPS; s++) side_r[s] <= side_r[s-1];
    for (int l = 0; l < 2; l++) begin
      k_r[l][0] <= k_nxt[l];
      for (int s = 1; s <= LOG_STEPS; s++) k_r[l][s] <= k_r[l][s-1];
      for (int s = 0; s <= LOG_STEPS; s++) begin
        m_r[l][s]    <= m_nxt[l][s];
        frac_r[l][s] <= frac_nxt[l][s];
      end
    end
  end

  assign out_valid = vld_r[LOG_STEPS];
  assign out_la    = {k_r[0][LOG_STEPS], frac_r[0][LOG_STEPS]};
  assign out_lb    = {k_r[1][LOG_STEPS], frac_r[1][LOG_STEPS]};
  assign out_side  = side_r[LOG_STEPS];

endmodule

// ===== hw/rtl/grlut_exp2.sv =====
// ----------------------------------------------------------------------------
// Pipelined negative exp2
// Forms 2^-y in Q1.32 from y with 30 fraction bits: one root multiply per
// stage, then the integer shift.
// ----------------------------------------------------------------------------
module grlut_exp2 import grlut_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [Y_W-1:0]     in_y,
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_valid,
  output logic [P_W-1:0]     out_p,
  output logic [SIDE_W-1:0]  out_side
);

  localparam logic [EXP_STEPS:1][31:0] ROOTS = root_table();

  logic [EXP_STEPS+1:0]  vld_r;
  logic [EXP_N_W-1:0]    n_r    [EXP_STEPS+1];
  logic [LOG_FRAC-1:0]   f_r    [EXP_STEPS+1];
  logic [P_W-1:0]        p_r    [EXP_STEPS+1];
  logic [SIDE_W-1:0]     side_r [EXP_STEPS+2];
  logic [P_W-1:0]        out_p_r;

  logic [P_W-1:0]        p_nxt  [EXP_STEPS+1];
  logic [P_W+31:0]       prod   [EXP_STEPS];
  logic [P_W-1:0]        out_p_nxt;

  // one conditional root multiply per stage, then the integer shift
  always_comb begin
    p_nxt[0] = P_W'(1) << 32;
    for (int j = 0; j < EXP_STEPS; j++) begin
      prod[j] = (P_W+32)'(p_r[j]) * (P_W+32)'(ROOTS[j+1]);
      if (f_r[j][LOG_FRAC-1-j]) begin
        p_nxt[j+1] = prod[j][P_W+31:32];
      end else begin
        p_nxt[j+1] = p_r[j];
      end
    end
    if (n_r[EXP_STEPS] >= EXP_N_W'(P_W)) begin
      out_p_nxt = '0;
    end else begin
      out_p_nxt = p_r[EXP_STEPS] >> n_r[EXP_STEPS];
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[EXP_STEPS:0], in_valid};
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    n_r[0]    <= in_y[Y_W-1:LOG_FRAC];
    f_r[0]    <= in_y[LOG_FRAC-1:0];
    side_r[0] <= in_side;
    for (int s = 1; s <= EXP_STEPS; s++) begin
      n_r[s] <= n_r[s-1];
      f_r[s] <= f_r[s-1];
    end
    for (int s = 1; s <= EXP_STEPS + 1; s++) side_r[s] <= side_r[s-1];
    for (int s = 0; s <= EXP_STEPS; s++) p_r[s] <= p_nxt[s];
    out_p_r <= out_p_nxt;
  end

  assign out_valid = vld_r[EXP_STEPS+1];
  assign out_p     = out_p_r;
  assign out_side  = side_r[EXP_STEPS+1];

endmodule

// ===== hw/rtl/gamma_ramp_entry_generator.sv =====
// Throughput: one entry per cycle; start is taken in every cycle out of reset.
// The pipeline holds 30 squaring stages of the log2 lanes and 30 root
// multiply stages of the exp2 unit, plus seven registers around them.
// Reset: synchronous, active low; clears the pipeline valid bits and restores
// the configuration registers; busy is high while reset is held.
// ----------------------------------------------------------------------------
// Gamma ramp entry generator
// Normalises an entry index, raises it to the channel exponent, applies the
// channel gain and rounds to a 16-bit ramp entry.
// ----------------------------------------------------------------------------
module gamma_ramp_entry_generator import grlut_pkg::*; #(
  parameter int INDEX_BITS     = DEF_INDEX_BITS,
  parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_channel,
  input  logic [IDX_W-1:0]  in_ramp_index,
  output logic              out_valid,
  output logic [15:0]       out_ramp_value,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [REG_W-1:0]  cfg_wdata
);

  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((32'd1 << INDEX_BITS) - 32'd1);

  logic [IDX_W-1:0]  ramp_size_r;
  logic [REG_W-1:0]  gain_r [3];
  logic [REG_W-1:0]  expo_r [3];

  logic              s0_vld_r;
  logic [1:0]        s0_ch_r;
  logic [IDX_W-1:0]  s0_idx_r;

  logic [REG_W-1:0]  gain_sel;
  logic [REG_W-1:0]  expo_sel;
  logic              ch_bad;
  logic [IDX_W-1:0]  size_m;
  logic [IDX_W-1:0]  size_m1;
  logic              size_gt1;
  logic [IDX_W-1:0]  idx_c;
  logic [IDX_W-1:0]  log_a;
  logic [IDX_W-1:0]  log_b;
  log_side_t         lside_in;

  logic              log_vld;
  logic [LOG_W-1:0]  log_la;
  logic [LOG_W-1:0]  log_lb;
  log_side_t         lside_out;

  logic [LOG_W-1:0]        d_val;
  logic [LOG_W+REG_W-1:0]  dy_prod;
  logic                    m_vld_r;
  logic [Y_W-1:0]          m_y_r;
  exp_side_t               m_side_r;

  logic              exp_vld;
  logic [P_W-1:0]    exp_p;
  exp_side_t         eside_out;

  logic [P_W-1:0]    p_sel;
  logic              v_vld_r;
  logic [V_W-1:0]    v_r;
  logic              v_zero_r;

  logic              sat;
  logic [31:0]       w_val;
  logic [48:0]       acc;
  logic [15:0]       res_nxt;
  logic              out_valid_r;
  logic [15:0]       out_value_r;

  assign busy = ~rst_n;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_size_r <= RST_RAMP_SIZE;
      for (int c = 0; c < 3; c++) begin
        gain_r[c] <= RST_GAIN;
        expo_r[c] <= RST_EXP;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RAMP_SIZE:  ramp_size_r <= cfg_wdata[IDX_W-1:0];
        CFG_RED_GAIN:   gain_r[0]   <= cfg_wdata;
        CFG_GREEN_GAIN: gain_r[1]   <= cfg_wdata;
        CFG_BLUE_GAIN:  gain_r[2]   <= cfg_wdata;
        CFG_RED_EXP:    expo_r[0]   <= cfg_wdata;
        CFG_GREEN_EXP:  expo_r[1]   <= cfg_wdata;
        CFG_BLUE_EXP:   expo_r[2]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // capture the input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_ch_r  <= in_channel;
    s0_idx_r <= in_ramp_index & IDX_MASK;
  end

  // select channel registers, clamp the index, flag the special cases
  always_comb begin
    ch_bad = 1'b0;
    unique case (ch_t'(s0_ch_r))
      CH_RED:   begin gain_sel = gain_r[0]; expo_sel = expo_r[0]; end
      CH_GREEN: begin gain_sel = gain_r[1]; expo_sel = expo_r[1]; end
      CH_BLUE:  begin gain_sel = gain_r[2]; expo_sel = expo_r[2]; end
      default:  begin gain_sel = '0; expo_sel = '0; ch_bad = 1'b1; end
    endcase
    size_m   = ramp_size_r & IDX_MASK;
    size_m1  = size_m - 1'b1;
    size_gt1 = size_m > IDX_W'(1);
    idx_c    = (size_gt1 && (s0_idx_r > size_m1)) ? size_m1 : s0_idx_r;
    log_a    = size_gt1 ? size_m1 : IDX_W'(1);
    log_b    = (idx_c == '0) ? IDX_W'(1) : idx_c;

    lside_in.zero   = ch_bad | gain_sel[REG_W-1] | (gain_sel == '0);
    lside_in.p_one  = (expo_sel == '0);
    lside_in.p_zero = ~size_gt1 | (idx_c == '0);
    lside_in.gain   = gain_sel[GAIN_W-1:0];
    lside_in.expo   = expo_sel;
  end

  grlut_log2 #(
    .SIDE_W ($bits(log_side_t))
  ) u_log2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_vld_r),
    .in_a      (log_a),
    .in_b      (log_b),
    .in_side   (lside_in),
    .out_valid (log_vld),
    .out_la    (log_la),
    .out_lb    (log_lb),
    .out_side  (lside_out)
  );

  // scale the log difference by the exponent
  always_comb begin
    d_val   = (log_la > log_lb) ? (log_la - log_lb) : '0;
    dy_prod = (LOG_W+REG_W)'(d_val) * (LOG_W+REG_W)'(lside_out.expo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= log_vld;
    end
  end

  always_ff @(posedge clk) begin
    m_y_r           <= dy_prod[LOG_W+REG_W-1:EXP_FRAC];
    m_side_r.zero   <= lside_out.zero;
    m_side_r.p_one  <= lside_out.p_one;
    m_side_r.p_zero <= lside_out.p_zero;
    m_side_r.gain   <= lside_out.gain;
  end

  grlut_exp2 #(
    .SIDE_W ($bits(exp_side_t))
  ) u_exp2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_vld_r),
    .in_y      (m_y_r),
    .in_side   (m_side_r),
    .out_valid (exp_vld),
    .out_p     (exp_p),
    .out_side  (eside_out)
  );

  // pick the power and apply the gain
  always_comb begin
    priority if (eside_out.p_one) begin
      p_sel = P_W'(1) << 32;
    end else if (eside_out.p_zero) begin
      p_sel = '0;
    end else begin
      p_sel = exp_p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_vld_r <= 1'b0;
    end else begin
      v_vld_r <= exp_vld;
    end
  end

  always_ff @(posedge clk) begin
    v_r      <= V_W'(p_sel) * V_W'(eside_out.gain);
    v_zero_r <= eside_out.zero;
  end

  // clamp and round to 16 bits: (w * 65535 + 2^31) >> 32
  always_comb begin
    sat   = (v_r >> (32 + GAIN_FRAC_BITS)) != '0;
    w_val = 32'(v_r >> GAIN_FRAC_BITS);
    acc   = ({1'b0, w_val, 16'd0} - {17'd0, w_val}) + (49'd1 << 31);
    priority if (v_zero_r) begin
      res_nxt = '0;
    end else if (sat) begin
      res_nxt = 16'hFFFF;
    end else begin
      res_nxt = acc[47:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ramp_value = out_value_r;

  // every transfer yields exactly one strobe a fixed latency later
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("transfer produced no result");

  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a transfer");

  a_bad_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_channel == CH_NONE) |-> ##PIPE_LAT (out_ramp_value == '0))
    else $error("unused channel gave a non-zero entry");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Gamma ramp entry generator testbench
// Drives index/channel commands through several register settings, predicts
// each ramp entry with a fixed-point log2/exp2 power model and checks every
// out_valid strobe in order against the predicted entries.
// ----------------------------------------------------------------------------
module tb;
  import grlut_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 67;
  localparam int MAX_CYCLE = 400000;

  // Ramp entry predictor and in-order store of expected entries
  class ramp_scoreboard;
    logic [15:0]      size_reg;
    logic [REG_W-1:0] gain_reg [3];
    logic [REG_W-1:0] expo_reg [3];
    logic [31:0]      roots [1:LOG_FRAC];
    logic [15:0]      entries [$];
    int               errors;

    function new();
      logic [63:0] r;
      size_reg = RST_RAMP_SIZE;
      for (int c = 0; c < 3; c++) begin
        gain_reg[c] = RST_GAIN;
        expo_reg[c] = RST_EXP;
      end
      errors = 0;
      // successive square roots of one half, Q0.32
      r = 64'd1 << 31;
      for (int k = 1; k <= LOG_FRAC; k++) begin
        r = root_of(r << 32);
        roots[k] = r[31:0];
      end
    endfunction

    // floor square root, result bits decided from the top down
    function logic [63:0] root_of(logic [63:0] v);
      logic [63:0] res, cand;
      res = '0;
      for (int b = 31; b >= 0; b--) begin
        cand = res | (64'd1 << b);
        if (cand * cand <= v) res = cand;
      end
      return res;
    endfunction

    // log2 of n >= 1 with LOG_FRAC fraction bits
    function logic [63:0] log2_q30(logic [31:0] n);
      int          k;
      logic [63:0] m, frac;
      k = 0;
      for (int i = 1; i < 32; i++) if ((n >> i) != 0) k = i;
      m    = 64'(n) << (31 - k);
      frac = '0;
      for (int b = 0; b < LOG_FRAC; b++) begin
        m    = (m * m) >> 31;
        frac = frac << 1;
        if (m[32]) begin
          frac = frac | 64'd1;
          m    = m >> 1;
        end
      end
      return (64'(k) << LOG_FRAC) | frac;
    endfunction

    // 2^-y, y with LOG_FRAC fraction bits, Q1.32 result
    function logic [63:0] pow2_neg(logic [63:0] y);
      logic [63:0] n, p;
      n = y >> LOG_FRAC;
      p = 64'd1 << 32;
      if (n >= 33) return '0;
      for (int k = 1; k <= LOG_FRAC; k++)
        if (y[LOG_FRAC-k]) p = (p * 64'(roots[k])) >> 32;
      return p >> n;
    endfunction

    function logic [15:0] ramp_entry(ch_t ch, logic [15:0] idx_in);
      logic [15:0]      idx;
      logic [REG_W-1:0] gain, e;
      logic [63:0]      p, v, w, ls, li, d, y;
      idx = idx_in;
      if (ch == CH_NONE) return '0;
      gain = gain_reg[ch];
      e    = expo_reg[ch];
      if (gain[REG_W-1] || gain == 0) return '0;
      if (size_reg > 1 && idx > size_reg - 16'd1) idx = size_reg - 16'd1;
      if (e == 0) p = 64'd1 << 32;
      else if (size_reg <= 1 || idx == 0) p = '0;
      else begin
        ls = log2_q30(32'(size_reg - 16'd1));
        li = log2_q30(32'(idx));
        d  = (ls > li) ? ls - li : 64'd0;
        y  = (d * 64'(e)) >> EXP_FRAC;
        p  = pow2_neg(y);
      end
      v = p * 64'(gain);
      if (v >= (64'd1 << 48)) return 16'hFFFF;
      w = v >> 16;
      return 16'((w * 64'd65535 + (64'd1 << 31)) >> 32);
    endfunction

    function void set_reg(cfg_idx_t idx, logic [REG_W-1:0] data);
      case (idx)
        CFG_RAMP_SIZE:  size_reg    = data[15:0];
        CFG_RED_GAIN:   gain_reg[0] = data;
        CFG_GREEN_GAIN: gain_reg[1] = data;
        CFG_BLUE_GAIN:  gain_reg[2] = data;
        CFG_RED_EXP:    expo_reg[0] = data;
        CFG_GREEN_EXP:  expo_reg[1] = data;
        CFG_BLUE_EXP:   expo_reg[2] = data;
        default: ;
      endcase
    endfunction

    function void note_transfer(ch_t ch, logic [15:0] idx);
      entries.push_back(ramp_entry(ch, idx));
    endfunction

    function void check_entry(logic [15:0] got);
      logic [15:0] want;
      if (entries.size() == 0) begin
        $display("%0t: unexpected ramp entry, expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = entries.pop_front();
      if (got !== want) begin
        $display("%0t: ramp_value mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_channel;
  logic [IDX_W-1:0] in_ramp_index;
  logic             out_valid;
  logic [15:0]      out_ramp_value;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [REG_W-1:0] cfg_wdata;

  ramp_scoreboard sb = new();
  int             cycles = 0;
  bit             allow_gaps;

  gamma_ramp_entry_generator uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_channel     (in_channel),
    .in_ramp_index  (in_ramp_index),
    .out_valid      (out_valid),
    .out_ramp_value (out_ramp_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Note command transfers and check strobed entries
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_transfer(ch_t'(in_channel), in_ramp_index);
      if (out_valid) sb.check_entry(out_ramp_value);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [REG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Issue one command, optionally after a random idle burst
  task automatic send_entry(logic [1:0] ch, logic [15:0] idx);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start         <= 1'b1;
    in_channel    <= ch;
    in_ramp_index <= idx;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every expected entry has arrived
  task automatic drain();
    start <= 1'b0;
    while (sb.entries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [REG_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0: return 20'd0;
      1: return 20'd1;
      2: return 20'd2;
      3: return 20'hFFFF;
      4: return 20'd256;
      5: return 20'($urandom_range(3, 64));
      default: return 20'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 20'd0;
      1: return 20'h7FFFF;
      2: return 20'h80000;
      3: return 20'h10000;
      4: return 20'($urandom_range(20'h8000, 20'h18000));
      default: return 20'($urandom());
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_expo();
    case ($urandom_range(0, 6))
      0: return 20'd0;
      1: return 20'hFFFFF;
      2: return 20'h10000;
      3: return 20'($urandom_range(20'h4000, 20'h40000));
      default: return 20'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_index();
    logic [15:0] sz;
    sz = sb.size_reg;
    case ($urandom_range(0, 5))
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 3));
      2: return 16'hFFFF;
      default: return 16'($urandom_range(0, sz));
    endcase
  endfunction

  initial begin
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_channel    <= '0;
    in_ramp_index <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    allow_gaps    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, edges of index, every channel incl. none
    send_entry(CH_RED, 16'd0);
    send_entry(CH_RED, 16'd1);
    send_entry(CH_GREEN, 16'd128);
    send_entry(CH_BLUE, 16'd255);
    send_entry(CH_BLUE, 16'd256);
    send_entry(CH_RED, 16'hFFFF);
    send_entry(CH_NONE, 16'd100);
    drain();

    // Directed: zero exponent, zero and negative gain, size one
    write_reg(CFG_RED_EXP, 20'd0);
    write_reg(CFG_GREEN_GAIN, 20'h80000);
    write_reg(CFG_BLUE_GAIN, 20'd0);
    write_reg(CFG_RAMP_SIZE, 20'd1);
    write_reg(CFG_UNUSED, 20'hABCDE);
    cfg_we <= 1'b0;
    send_entry(CH_RED, 16'd0);
    send_entry(CH_RED, 16'd5);
    send_entry(CH_GREEN, 16'd0);
    send_entry(CH_BLUE, 16'd7);
    drain();

    // Directed: largest size, largest gain and exponent
    write_reg(CFG_RAMP_SIZE, 20'hFFFF);
    write_reg(CFG_RED_EXP, 20'hFFFFF);
    write_reg(CFG_GREEN_GAIN, 20'h7FFFF);
    write_reg(CFG_BLUE_GAIN, 20'h10000);
    write_reg(CFG_BLUE_EXP, 20'h23333);
    cfg_we <= 1'b0;
    send_entry(CH_RED, 16'hFFFE);
    send_entry(CH_RED, 16'hFFFF);
    send_entry(CH_GREEN, 16'd1);
    send_entry(CH_GREEN, 16'h8000);
    send_entry(CH_BLUE, 16'd0);
    send_entry(CH_BLUE, 16'h7FFF);
    drain();

    // Random phases, each with fresh register settings
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(CFG_RAMP_SIZE, pick_size());
      write_reg(CFG_RED_GAIN, pick_gain());
      write_reg(CFG_GREEN_GAIN, pick_gain());
      write_reg(CFG_BLUE_GAIN, pick_gain());
      write_reg(CFG_RED_EXP, pick_expo());
      write_reg(CFG_GREEN_EXP, pick_expo());
      write_reg(CFG_BLUE_EXP, pick_expo());
      cfg_we     <= 1'b0;
      allow_gaps = (ph < 8) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 110; i++) begin
        send_entry(($urandom_range(0, 9) == 0) ? 2'(CH_NONE) : 2'($urandom_range(0, 2)),
                   pick_index());
      end
      drain();
    end

    // Let the pipeline settle before the verdict
    start <= 1'b0;
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0 && sb.entries.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/grlut_pkg.sv
hw/rtl/grlut_log2.sv
hw/rtl/grlut_exp2.sv
hw/rtl/gamma_ramp_entry_generator.sv
dv/tb.sv
